// ===== rtl/nca_pkg.sv =====
`default_nettype none

package nca_pkg;

  // Default sizes of the block.
  localparam int MAX_CLUSTERS_DEF = 16;
  localparam int MAX_DIMS_DEF     = 16;
  localparam int VALUE_BITS_DEF   = 16;

  // Fixed field widths of the interface.
  localparam int OPCODE_W   = 2;
  localparam int SEL_W      = 4;
  localparam int ELEM_W     = 4;
  localparam int VALUE_W    = 16;
  localparam int IDX_OUT_W  = 4;
  localparam int DIST_W     = 39;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // Reset values of the configuration registers.
  localparam logic [CFG_DATA_W-1:0] CLUSTERS_USED_RST = CFG_DATA_W'(16);
  localparam logic [CFG_DATA_W-1:0] DIMS_USED_RST     = CFG_DATA_W'(16);

  // Opcodes.
  localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_POINT = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CLUSTERS_USED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIMS_USED     = 2'd1;

  typedef struct packed {
    logic [OPCODE_W-1:0]       opcode;
    logic [SEL_W-1:0]          cluster_select;
    logic [ELEM_W-1:0]         element_index;
    logic signed [VALUE_W-1:0] value;
  } nca_in_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] cluster_index;
    logic [DIST_W-1:0]    squared_distance;
    logic [CNT_W-1:0]     cluster_count;
  } nca_out_t;

  // Control strobes broadcast from the sequencer to every cell.
  typedef struct packed {
    logic load;     // write one centroid element
    logic rd;       // read the centroid element at the current position
    logic sq;       // square the difference
    logic acc;      // add the square to the running sum
    logic clr_sum;  // clear the running sums
    logic clr_cnt;  // clear the member counts
    logic bump;     // increment the winner's member count
  } nca_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/nca_cell.sv =====
`default_nettype none

module nca_cell
  import nca_pkg::*;
#(
  parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
  parameter int MAX_DIMS     = MAX_DIMS_DEF,
  parameter int VALUE_BITS   = VALUE_BITS_DEF,
  parameter int CELL_ID      = 0,
  localparam int AW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
  localparam int IDX_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1,
  localparam int CW    = $clog2(MAX_CLUSTERS + 1),
  localparam int SQ_W  = 2 * VALUE_BITS,
  localparam int SUM_W = SQ_W + $clog2(MAX_DIMS)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire nca_ctl_t              ctl,
  input  wire logic [SEL_W-1:0]      ld_cluster,
  input  wire logic [AW-1:0]         ld_addr,
  input  wire logic [VALUE_BITS-1:0] ld_value,
  input  wire logic [AW-1:0]         rd_addr,
  input  wire logic [VALUE_BITS-1:0] pt_value,
  input  wire logic [CW-1:0]         ncl,
  input  wire logic [IDX_W-1:0]      bump_idx,
  input  wire logic                  ch_vld_in,
  input  wire logic                  ch_has_in,
  input  wire logic [IDX_W-1:0]      ch_idx_in,
  input  wire logic [SUM_W-1:0]      ch_dist_in,
  input  wire logic [CNT_W-1:0]      ch_cnt_in,
  output      logic                  ch_vld_r,
  output      logic                  ch_has_r,
  output      logic [IDX_W-1:0]      ch_idx_r,
  output      logic [SUM_W-1:0]      ch_dist_r,
  output      logic [CNT_W-1:0]      ch_cnt_r
);

  logic [VALUE_BITS-1:0] mem [MAX_DIMS];
  logic [VALUE_BITS-1:0] rdata_r;
  logic [SQ_W-1:0]       sq_r;
  logic [SUM_W-1:0]      sum_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [CNT_W-1:0]      cnt_inc;

  logic signed [VALUE_BITS:0]       diff;
  logic signed [2*VALUE_BITS+1:0]   prod;
  logic                             in_use;
  logic                             take;
  logic                             hit_ld;
  logic                             hit_bump;

  assign hit_ld   = ctl.load && (32'(ld_cluster) == CELL_ID);
  assign hit_bump = ctl.bump && (bump_idx == IDX_W'(CELL_ID));
  assign in_use   = (32'(ncl) > CELL_ID);
  assign cnt_inc  = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;

  assign diff = $signed({pt_value[VALUE_BITS-1], pt_value})
              - $signed({rdata_r[VALUE_BITS-1], rdata_r});
  assign prod = diff * diff;

  // Strictly closer wins, so an earlier cell keeps the best on a tie.
  assign take = in_use && (!ch_has_in || (ch_dist_in > sum_r));

  always_ff @(posedge clk) begin
    if (hit_ld) begin
      mem[ld_addr] <= ld_value;
    end
    if (ctl.rd) begin
      rdata_r <= mem[rd_addr];
    end
    if (ctl.sq) begin
      sq_r <= prod[SQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      cnt_r    <= '0;
      ch_vld_r <= 1'b0;
    end else begin
      if (ctl.clr_sum) begin
        sum_r <= '0;
      end else if (ctl.acc) begin
        sum_r <= sum_r + SUM_W'(sq_r);
      end
      if (ctl.clr_cnt) begin
        cnt_r <= '0;
      end else if (hit_bump) begin
        cnt_r <= cnt_inc;
      end
      ch_vld_r <= ch_vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ch_has_r  <= 1'b1;
      ch_idx_r  <= IDX_W'(CELL_ID);
      ch_dist_r <= sum_r;
      ch_cnt_r  <= cnt_inc;
    end else begin
      ch_has_r  <= ch_has_in;
      ch_idx_r  <= ch_idx_in;
      ch_dist_r <= ch_dist_in;
      ch_cnt_r  <= ch_cnt_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nearest_centroid_assign_core.sv =====
// Nearest-centroid assignment over a row of MAX_CLUSTERS cells, one per
// centroid, each holding its centroid elements, its running squared distance
// and its member count. A load or clear beat is acted on as it is accepted. A
// point element goes through three steps (centroid read, square, accumulate),
// all cells working in parallel. The last element of a point then sends a
// best-so-far token down the cell row, one cell per cycle; the next beat is
// taken only after the token leaves the row. The result sits in an output register;
// a new point can stream in while it waits, but the next comparison pass
// starts only once the previous result has left. Centroid elements that were
// never loaded read back as unknown values.

`default_nettype none

module nearest_centroid_assign_core
  import nca_pkg::*;
#(
  parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
  parameter int MAX_DIMS     = MAX_DIMS_DEF,
  parameter int VALUE_BITS   = VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire nca_in_t               in_data,
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      nca_out_t              out_data,
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int PW    = $clog2(MAX_DIMS + 1);
  localparam int IDX_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int CW    = $clog2(MAX_CLUSTERS + 1);
  localparam int SUM_W = 2 * VALUE_BITS + $clog2(MAX_DIMS);
  localparam int RW    = (VALUE_BITS > VALUE_W) ? VALUE_BITS : VALUE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ,
    S_ACC,
    S_LAUNCH,
    S_WAIT
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_DATA_W-1:0] clusters_used_r;
  logic [CFG_DATA_W-1:0] dims_used_r;
  logic [PW-1:0]         pos_r;
  logic [VALUE_BITS-1:0] value_r;
  logic                  out_valid_r;
  nca_out_t              out_r;

  logic [PW-1:0]         dims_eff;
  logic [CW-1:0]         ncl;
  logic [AW-1:0]         pos_rd;
  logic [PW-1:0]         pos_next;
  logic                  last_elem;
  logic [RW-1:0]         raw_ext;
  logic [VALUE_BITS-1:0] in_val;
  logic                  in_acc;
  logic                  start;
  nca_ctl_t              ctl;

  logic                  ch_vld  [MAX_CLUSTERS+1];
  logic                  ch_has  [MAX_CLUSTERS+1];
  logic [IDX_W-1:0]      ch_idx  [MAX_CLUSTERS+1];
  logic [SUM_W-1:0]      ch_dist [MAX_CLUSTERS+1];
  logic [CNT_W-1:0]      ch_cnt  [MAX_CLUSTERS+1];

  logic [SUM_W+DIST_W-1:0]     dist_ext;
  logic [IDX_W+IDX_OUT_W-1:0]  idx_ext;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The value field is taken as raw bits and cut or zero-extended to VALUE_BITS.
  assign raw_ext = RW'($unsigned(in_data.value));
  assign in_val  = raw_ext[VALUE_BITS-1:0];

  always_comb begin
    if (dims_used_r == '0) begin
      dims_eff = PW'(1);
    end else if (32'(dims_used_r) > MAX_DIMS) begin
      dims_eff = PW'(MAX_DIMS);
    end else begin
      dims_eff = PW'(dims_used_r);
    end
    if (clusters_used_r == '0) begin
      ncl = CW'(1);
    end else if (32'(clusters_used_r) > MAX_CLUSTERS) begin
      ncl = CW'(MAX_CLUSTERS);
    end else begin
      ncl = CW'(clusters_used_r);
    end
  end

  assign pos_rd    = (32'(pos_r) >= MAX_DIMS) ? AW'(MAX_DIMS - 1) : AW'(pos_r);
  assign pos_next  = PW'(pos_rd) + 1'b1;
  assign last_elem = (pos_next >= dims_eff);
  assign start     = (state_r == S_LAUNCH) && !out_valid_r;

  always_comb begin
    ctl         = '0;
    ctl.load    = in_acc && (in_data.opcode == OP_LOAD)
                && (32'(in_data.element_index) < MAX_DIMS);
    ctl.rd      = in_acc && (in_data.opcode == OP_POINT);
    ctl.clr_cnt = in_acc && (in_data.opcode == OP_CLEAR);
    ctl.sq      = (state_r == S_SQ);
    ctl.acc     = (state_r == S_ACC);
    ctl.bump    = (state_r == S_WAIT) && ch_vld[MAX_CLUSTERS];
    ctl.clr_sum = ctl.bump;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (ctl.rd) begin
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        state_nxt = S_ACC;
      end
      S_ACC: begin
        state_nxt = last_elem ? S_LAUNCH : S_IDLE;
      end
      S_LAUNCH: begin
        if (start) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (ch_vld[MAX_CLUSTERS]) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign dist_ext = (SUM_W+DIST_W)'(ch_dist[MAX_CLUSTERS]);
  assign idx_ext  = (IDX_W+IDX_OUT_W)'(ch_idx[MAX_CLUSTERS]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      clusters_used_r <= CLUSTERS_USED_RST;
      dims_used_r     <= DIMS_USED_RST;
      pos_r           <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CLUSTERS_USED: clusters_used_r <= cfg_data;
          REG_DIMS_USED:     dims_used_r     <= cfg_data;
          default: begin
          end
        endcase
      end
      if (state_r == S_ACC) begin
        pos_r <= last_elem ? '0 : pos_next;
      end
      if (ctl.bump) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      value_r <= in_val;
    end
    if (ctl.bump) begin
      out_r.cluster_index    <= idx_ext[IDX_OUT_W-1:0];
      out_r.squared_distance <= dist_ext[DIST_W-1:0];
      out_r.cluster_count    <= ch_cnt[MAX_CLUSTERS];
    end
  end

  // The token enters the first cell with no best yet.
  assign ch_vld[0]  = start;
  assign ch_has[0]  = 1'b0;
  assign ch_idx[0]  = '0;
  assign ch_dist[0] = '0;
  assign ch_cnt[0]  = '0;

  for (genvar c = 0; c < MAX_CLUSTERS; c++) begin : g_cell
    nca_cell #(
      .MAX_CLUSTERS (MAX_CLUSTERS),
      .MAX_DIMS     (MAX_DIMS),
      .VALUE_BITS   (VALUE_BITS),
      .CELL_ID      (c)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .ld_cluster (in_data.cluster_select),
      .ld_addr    (AW'(in_data.element_index)),
      .ld_value   (in_val),
      .rd_addr    (pos_rd),
      .pt_value   (value_r),
      .ncl        (ncl),
      .bump_idx   (ch_idx[MAX_CLUSTERS]),
      .ch_vld_in  (ch_vld[c]),
      .ch_has_in  (ch_has[c]),
      .ch_idx_in  (ch_idx[c]),
      .ch_dist_in (ch_dist[c]),
      .ch_cnt_in  (ch_cnt[c]),
      .ch_vld_r   (ch_vld[c+1]),
      .ch_has_r   (ch_has[c+1]),
      .ch_idx_r   (ch_idx[c+1]),
      .ch_dist_r  (ch_dist[c+1]),
      .ch_cnt_r   (ch_cnt[c+1])
    );
  end

endmodule

`default_nettype wire
